>>> rtl/core/dsp_pkg.sv
// Shared types, constants and bound helpers for the date string parser.
package dsp_pkg;

  localparam int unsigned VAL_W = 14;

  localparam logic [VAL_W-1:0] YEAR_MAX  = 14'd9999;
  localparam logic [VAL_W-1:0] MONTH_MAX = 14'd12;
  localparam logic [VAL_W-1:0] DAY_MAX   = 14'd31;

  localparam logic [2:0] YEAR_DIGITS  = 3'd4;
  localparam logic [2:0] FIELD_DIGITS = 3'd2;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_SPARE
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic             in_digits;
    logic             finished;
    logic [VAL_W-1:0] acc;
    logic [2:0]       digits_left;
    logic [VAL_W-1:0] year_held;
    logic [3:0]       month_held;
  } parse_state_t;

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] year;
    logic [3:0]       month;
    logic [4:0]       day;
  } date_res_t;

  function automatic logic [VAL_W-1:0] upper_bound(phase_t ph);
    logic [VAL_W-1:0] ub;
    case (ph)
      PH_YEAR:  ub = YEAR_MAX;
      PH_MONTH: ub = MONTH_MAX;
      default:  ub = DAY_MAX;
    endcase
    return ub;
  endfunction

  // a*10 > ub is the same as a > floor(ub/10)
  function automatic logic [VAL_W-1:0] upper_tenth(phase_t ph);
    logic [VAL_W-1:0] ut;
    case (ph)
      PH_YEAR:  ut = YEAR_MAX / 14'd10;
      PH_MONTH: ut = MONTH_MAX / 14'd10;
      default:  ut = DAY_MAX / 14'd10;
    endcase
    return ut;
  endfunction

endpackage

>>> rtl/core/dsp_step.sv
// Combinational next-state and result logic for one character.
module dsp_step import dsp_pkg::*; (
  input  parse_state_t state_i,
  input  logic [7:0]   char_i,
  input  logic         eos_i,
  output parse_state_t state_o,
  output logic         emit_o,
  output date_res_t    res_o
);

  parse_state_t     st;
  logic             digit;
  logic             sep;
  logic [VAL_W-1:0] dval;
  logic [16:0]      acc_mul;
  logic [VAL_W-1:0] v;
  logic             need_close;
  logic             trail;
  logic             emit;
  date_res_t        res;
  logic [VAL_W-1:0] lb;

  always_comb begin
    st         = state_i;
    digit      = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    sep        = (char_i == CH_DASH) || (char_i == CH_SPACE);
    dval       = {{(VAL_W-4){1'b0}}, char_i[3:0]};
    acc_mul    = {3'b000, state_i.acc} * 17'd10 + {3'b000, dval};
    v          = st.acc;
    need_close = 1'b0;
    trail      = 1'b0;
    emit       = 1'b0;
    res        = '0;
    lb         = '0;

    if (!state_i.finished) begin
      if (state_i.in_digits) begin
        if (digit) begin
          st.acc         = acc_mul[VAL_W-1:0];
          st.digits_left = state_i.digits_left - 3'd1;
          need_close     = (st.digits_left == 3'd0) || (st.acc > upper_tenth(st.phase));
        end else begin
          need_close = 1'b1;
          trail      = 1'b1;
        end
      end else if (!sep) begin
        if (!digit) begin
          emit = 1'b1;
          res  = '{status: 1'b1, default: '0};
        end else begin
          st.acc         = dval;
          st.digits_left = ((st.phase == PH_YEAR) ? YEAR_DIGITS : FIELD_DIGITS) - 3'd1;
          st.in_digits   = 1'b1;
          need_close     = (st.digits_left == 3'd0) || (st.acc > upper_tenth(st.phase));
        end
      end

      // close the current field
      if (need_close) begin
        v            = st.acc;
        lb           = (st.phase == PH_YEAR) ? 14'd0 : 14'd1;
        st.in_digits = 1'b0;
        if ((v < lb) || (v > upper_bound(st.phase))) begin
          emit = 1'b1;
          res  = '{status: 1'b1, default: '0};
        end else if (st.phase == PH_YEAR) begin
          st.year_held = v;
          st.phase     = PH_MONTH;
          st.acc       = '0;
        end else if (st.phase == PH_MONTH) begin
          st.month_held = v[3:0] - 4'd1;
          st.phase      = PH_DAY;
          st.acc        = '0;
        end else begin
          emit = 1'b1;
          res  = '{status: 1'b0, year: st.year_held, month: st.month_held, day: v[4:0]};
        end
      end

      // non-digit that ended a field is looked at again as a separator
      if (trail && !emit && !sep) begin
        emit = 1'b1;
        res  = '{status: 1'b1, default: '0};
      end

      // end of string mid-parse: the end-of-string flag always yields a result
      if (eos_i && !emit) begin
        emit = 1'b1;
        if (st.in_digits && st.phase[1] && (st.acc >= 14'd1) && (st.acc <= DAY_MAX)) begin
          res = '{status: 1'b0, year: st.year_held, month: st.month_held,
                  day: st.acc[4:0]};
        end else begin
          res = '{status: 1'b1, default: '0};
        end
      end

      if (emit) begin
        st.finished = 1'b1;
      end
    end

    if (eos_i) begin
      st = '0;
    end

    state_o = st;
    emit_o  = emit;
    res_o   = res;
  end

endmodule

>>> rtl/core/date_string_parser_unit.sv
// Top level of the date string parser: input register, parse step, result register.
//
// Input channel: one ASCII character per word on in_char_code, with
// in_end_of_string high on the last character of a string. A word is taken
// on an edge where in_valid is high and in_stall is low.
// Result channel: out_status, out_year, out_month (month minus one) and
// out_day, taken on an edge where out_valid is high and out_stall is low.
// At most one result per string: on the day field closing, on the first error
// or at the end of string; later characters up to the end of string give nothing.
// Throughput is one word per cycle while no result waits on out_stall. A
// character enters the input register, and its result, if any, is then
// written to the result register, which raises out_valid. The whole parse step
// is one pass of decimal accumulate and bound compare.
// When out_stall holds a waiting result, the input register may still take
// one word; in_stall then stays high while that word is held, whether or not
// it would give a result. Reset (rst_n low, synchronous) empties both
// registers and returns the parser to the start of a string.
module date_string_parser_unit import dsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char_code,
  input  logic             in_end_of_string,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_status,
  output logic [VAL_W-1:0] out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day
);

  logic         s1_valid_r;
  logic [7:0]   s1_char_r;
  logic         s1_eos_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         out_valid_r;
  date_res_t    out_res_r;
  logic         step_emit;
  date_res_t    step_res;
  logic         adv;

  dsp_step u_step (
    .state_i (state_r),
    .char_i  (s1_char_r),
    .eos_i   (s1_eos_r),
    .state_o (state_nxt),
    .emit_o  (step_emit),
    .res_o   (step_res)
  );

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r && step_emit;
        if (s1_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_char_r <= in_char_code;
      s1_eos_r  <= in_end_of_string;
    end
    if (adv && s1_valid_r && step_emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_res_r.status;
  assign out_year   = out_res_r.year;
  assign out_month  = out_res_r.month;
  assign out_day    = out_res_r.day;

`ifndef ASSERT_OFF
  // once a result leaves mid-string, the parser stays silent until end of string
  a_finished_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_valid_r && step_emit && !s1_eos_r |=> state_r.finished)
    else $error("parser not marked finished after a result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status |->
      (out_res_r.year == '0) && (out_res_r.month == '0) && (out_res_r.day == '0))
    else $error("error result carries non-zero fields");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.status |->
      (out_res_r.month <= 4'd11) && (out_res_r.day != 5'd0)
      && (out_res_r.year <= YEAR_MAX))
    else $error("parsed date out of range");

  a_no_result_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && state_r.finished |-> !step_emit)
    else $error("second result within one string");
`endif

endmodule
